// File: src/aprd_pkg.sv
// Shared types and constants of the AIS position report decoder.
package aprd_pkg;

   // character codes the front watches for
   localparam logic [7:0] CHAR_BANG  = 8'h21;   // '!'
   localparam logic [7:0] CHAR_A     = 8'h41;   // 'A'
   localparam logic [7:0] CHAR_I     = 8'h49;   // 'I'
   localparam logic [7:0] CHAR_COMMA = 8'h2C;   // ','

   // armored symbol ranges
   localparam logic [7:0] ARMOR_LO_FIRST = 8'd48;
   localparam logic [7:0] ARMOR_LO_LAST  = 8'd87;
   localparam logic [7:0] ARMOR_HI_FIRST = 8'd96;
   localparam logic [7:0] ARMOR_HI_LAST  = 8'd119;
   localparam logic [7:0] ARMOR_HI_BIAS  = 8'd56;

   localparam int SYM_W = 6;

   // field (counted from zero) that holds the payload
   localparam logic [2:0] PAYLOAD_FIELD = 3'd5;
   localparam logic [2:0] COMMA_MAX     = 3'd7;

   // only the first NEEDED_BITS payload bits reach a report
   localparam int NEEDED_BITS = 137;
   localparam int BIT_CNT_W   = $clog2(NEEDED_BITS + 1);
   localparam logic [BIT_CNT_W-1:0] BIT_CNT_MAX = BIT_CNT_W'(NEEDED_BITS);

   // range limits
   localparam logic [9:0]  SOG_MAX = 10'd1022;
   localparam logic [11:0] COG_MAX = 12'd3600;
   localparam logic [8:0]  HDG_MAX = 9'd360;
   localparam logic [8:0]  HDG_NA  = 9'd511;
   localparam logic signed [27:0] LON_LIMIT = 28'sd108000000;
   localparam logic signed [26:0] LAT_LIMIT = 27'sd54000000;

   // default queue depths
   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   // classified character, front to back
   typedef struct packed {
      logic             sym_valid;
      logic [SYM_W-1:0] sym;
      logic             last;
      logic             tag;
   } cmd_type;

   // one position report
   typedef struct packed {
      logic [29:0] user_id;
      logic [9:0]  sog_tenths;
      logic [27:0] lon_raw;
      logic [26:0] lat_raw;
      logic [11:0] cog_tenths;
      logic [8:0]  heading_deg;
      logic        out_of_range;
      logic        short_payload;
   } rsp_type;

   // back handshake status seen by the top level
   typedef struct packed {
      logic cmd_pop;
      logic out_push;
      logic snap_valid;
   } back_status_type;

endpackage

// File: src/aprd_queue.sv
// Small first-in first-out queue used between the front, the back and the result port.
module aprd_queue
   import aprd_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_DEPTH);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/aprd_front.sv
// Front end: tag detection, field counting and de-armoring of each character.
module aprd_front
   import aprd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   input  logic       end_of_sentence,
   output cmd_type    cmd
);

   logic [15:0] window_ff, window_in;
   logic        tag_ff, tag_in;
   logic [2:0]  comma_ff, comma_in;

   logic             is_comma;
   logic             tag_now;
   logic             sym_ok;
   logic [SYM_W-1:0] sym;

   always_comb begin
      is_comma = (char_code == CHAR_COMMA);
      tag_now  = tag_ff || (char_code == CHAR_I && window_ff[7:0] == CHAR_A &&
                            window_ff[15:8] == CHAR_BANG);

      sym_ok = 1'b0;
      sym    = '0;
      if (char_code >= ARMOR_LO_FIRST && char_code <= ARMOR_LO_LAST) begin
         sym_ok = 1'b1;
         sym    = SYM_W'(char_code - ARMOR_LO_FIRST);
      end else if (char_code >= ARMOR_HI_FIRST && char_code <= ARMOR_HI_LAST) begin
         sym_ok = 1'b1;
         sym    = SYM_W'(char_code - ARMOR_HI_BIAS);
      end

      cmd.sym_valid = sym_ok && !is_comma && (comma_ff == PAYLOAD_FIELD);
      cmd.sym       = sym;
      cmd.last      = end_of_sentence;
      cmd.tag       = tag_now;

      window_in = window_ff;
      tag_in    = tag_ff;
      comma_in  = comma_ff;
      if (accept) begin
         if (end_of_sentence) begin
            // start the next sentence clean
            window_in = '0;
            tag_in    = 1'b0;
            comma_in  = '0;
         end else begin
            window_in = {window_ff[7:0], char_code};
            tag_in    = tag_now;
            if (is_comma && comma_ff != COMMA_MAX) begin
               comma_in = comma_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         tag_ff    <= 1'b0;
         comma_ff  <= '0;
      end else begin
         window_ff <= window_in;
         tag_ff    <= tag_in;
         comma_ff  <= comma_in;
      end
   end

endmodule

// File: src/aprd_back.sv
// Back end: payload bit store, end-of-sentence snapshot and report extraction.
module aprd_back
   import aprd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_empty,
   input  cmd_type         cmd,
   output logic            cmd_pop,
   input  logic            out_full,
   output logic            out_push,
   output rsp_type         out_data,
   output back_status_type status
);

   localparam logic [BIT_CNT_W:0] SYM_BITS = (BIT_CNT_W + 1)'(SYM_W);

   logic [0:NEEDED_BITS-1] store_ff, store_in, store_upd;
   logic [BIT_CNT_W-1:0]   count_ff, count_in, count_upd;
   logic [0:NEEDED_BITS-1] snap_ff, snap_in;
   logic                   snap_short_ff, snap_short_in;
   logic                   snap_valid_ff, snap_valid_in;

   logic               report;
   logic [BIT_CNT_W:0] count_sum;
   logic [BIT_CNT_W:0] offset;

   logic signed [27:0] lon;
   logic signed [26:0] lat;

   always_comb begin
      out_push = snap_valid_ff && !out_full;
      report   = cmd.last && cmd.tag;
      // a report needs the snapshot slot, free now or freed this cycle
      cmd_pop  = !cmd_empty && (!report || !snap_valid_ff || out_push);

      count_sum = {1'b0, count_ff} + SYM_BITS;
      count_upd = count_ff;
      if (cmd.sym_valid) begin
         count_upd = (count_sum > {1'b0, BIT_CNT_MAX}) ? BIT_CNT_MAX
                                                       : count_sum[BIT_CNT_W-1:0];
      end

      // place the six symbol bits MSB first at the fill position
      store_upd = store_ff;
      offset    = '0;
      for (int i = 0; i < NEEDED_BITS; i++) begin
         offset = (BIT_CNT_W + 1)'(i) - {1'b0, count_ff};
         if (cmd.sym_valid && (BIT_CNT_W + 1)'(i) >= {1'b0, count_ff} &&
             (BIT_CNT_W + 1)'(i) < count_sum) begin
            store_upd[i] = cmd.sym[3'd5 - offset[2:0]];
         end
      end

      store_in      = store_ff;
      count_in      = count_ff;
      snap_in       = snap_ff;
      snap_short_in = snap_short_ff;
      snap_valid_in = snap_valid_ff && !out_push;
      if (cmd_pop) begin
         if (cmd.last) begin
            store_in = '0;
            count_in = '0;
            if (report) begin
               snap_in       = store_upd;
               snap_short_in = (count_upd < BIT_CNT_MAX);
               snap_valid_in = 1'b1;
            end
         end else begin
            store_in = store_upd;
            count_in = count_upd;
         end
      end
   end

   always_comb begin
      lon = $signed(snap_ff[61:88]);
      lat = $signed(snap_ff[89:115]);

      out_data.user_id       = snap_ff[8:37];
      out_data.sog_tenths    = snap_ff[50:59];
      out_data.lon_raw       = snap_ff[61:88];
      out_data.lat_raw       = snap_ff[89:115];
      out_data.cog_tenths    = snap_ff[116:127];
      out_data.heading_deg   = snap_ff[128:136];
      out_data.short_payload = snap_short_ff;
      out_data.out_of_range  =
         (out_data.sog_tenths > SOG_MAX) ||
         (out_data.cog_tenths > COG_MAX) ||
         (lon > LON_LIMIT) || (lon < -LON_LIMIT) ||
         (lat > LAT_LIMIT) || (lat < -LAT_LIMIT) ||
         (out_data.heading_deg > HDG_MAX && out_data.heading_deg != HDG_NA);

      status.cmd_pop    = cmd_pop;
      status.out_push   = out_push;
      status.snap_valid = snap_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff      <= '0;
         count_ff      <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         store_ff      <= store_in;
         count_ff      <= count_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff       <= snap_in;
      snap_short_ff <= snap_short_in;
   end

endmodule

// File: src/ais_position_report_decoder_top.sv
// Top level of the AIS position report decoder: front, command queue, back, result queue.
//
//   channel   ports                            handshake
//   request   req_char_code, req_end_of_sentence   req_push / req_full
//   response  rsp_user_id .. rsp_short_payload     rsp_pop / rsp_empty
//
// One character is accepted every cycle while req_full is low.
// A report reaches the result ports through the snapshot register and then the result
// queue; an occupied snapshot register or a full result queue can hold it back.
// Reset empties both queues and clears the sentence state and bit store.
// req_full rises only when the command queue fills: the result queue is full, the
// snapshot register holds a report and the next report waits at the command queue head.
module ais_position_report_decoder_top
   import aprd_pkg::*;
#(
   parameter int CMD_DEPTH = CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH = RSP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_sentence,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [29:0] rsp_user_id,
   output logic [9:0]  rsp_sog_tenths,
   output logic [27:0] rsp_lon_raw,
   output logic [26:0] rsp_lat_raw,
   output logic [11:0] rsp_cog_tenths,
   output logic [8:0]  rsp_heading_deg,
   output logic        rsp_out_of_range,
   output logic        rsp_short_payload
);

   cmd_type         front_cmd;
   cmd_type         back_cmd;
   logic            cmd_empty;
   logic            cmd_pop;
   logic            out_full;
   logic            out_push;
   rsp_type         back_rsp;
   rsp_type         rsp_head;
   back_status_type back_status;
   logic            req_accept;

   assign req_accept = req_push && !req_full;

   aprd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .char_code       (req_char_code),
      .end_of_sentence (req_end_of_sentence),
      .cmd             (front_cmd)
   );

   aprd_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmd_empty)
   );

   aprd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (back_cmd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (back_rsp),
      .status    (back_status)
   );

   aprd_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_user_id       = rsp_head.user_id;
   assign rsp_sog_tenths    = rsp_head.sog_tenths;
   assign rsp_lon_raw       = rsp_head.lon_raw;
   assign rsp_lat_raw       = rsp_head.lat_raw;
   assign rsp_cog_tenths    = rsp_head.cog_tenths;
   assign rsp_heading_deg   = rsp_head.heading_deg;
   assign rsp_out_of_range  = rsp_head.out_of_range;
   assign rsp_short_payload = rsp_head.short_payload;

`ifndef SYNTHESIS
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      back_status.out_push |-> !out_full && back_status.snap_valid)
      else $error("report pushed into a full result queue");

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      back_status.cmd_pop |-> !cmd_empty)
      else $error("back took a command from an empty queue");

   a_report_lands: assert property (@(posedge clock) disable iff (reset)
      back_status.out_push |=> !rsp_empty)
      else $error("pushed report missing from the result queue");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty && cmd_empty && !back_status.snap_valid)
      else $error("queues not empty after reset");
`endif

endmodule
